/* rtl/opte_pkg.sv */
package opte_pkg;

  // Operation codes of an input request.
  localparam logic [2:0] OpStartShades = 3'd0;
  localparam logic [2:0] OpStartCrt    = 3'd1;
  localparam logic [2:0] OpFrameBegin  = 3'd2;
  localparam logic [2:0] OpPixel       = 3'd3;
  localparam logic [2:0] OpFrameEnd    = 3'd4;

  // Effect codes as reported on active_effect.
  localparam logic [1:0] FxIdle   = 2'd0;
  localparam logic [1:0] FxShades = 2'd1;
  localparam logic [1:0] FxCrt    = 2'd2;

  // Command queue between front and back.
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  typedef struct packed {
    logic [2:0] operation;
    logic       direction;
    logic [2:0] page_index;
    logic [6:0] column_index;
    logic [7:0] new_byte;
    logic [7:0] old_byte;
  } in_req_t;

  typedef struct packed {
    logic [7:0] pixel_out;
    logic [1:0] active_effect;
    logic       finish_flag;
  } out_req_t;

  typedef enum logic [2:0] {
    KindStartShades,
    KindStartCrt,
    KindFrameBegin,
    KindPixel,
    KindFrameEnd,
    KindNone
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic       direction;
    logic [2:0] page_index;
    logic [6:0] column_index;
    logic [7:0] new_byte;
    logic [7:0] old_byte;
  } cmd_t;

  typedef struct packed {
    logic                empty;
    logic                full;
    logic [FifoCntW-1:0] count;
  } fifo_status_t;

endpackage

/* rtl/opte_front.sv */
module opte_front (
  input  logic                  in_valid_i,
  input  opte_pkg::in_req_t     in_req_i,
  output logic                  in_ready_o,
  input  opte_pkg::fifo_status_t fifo_status_i,
  output logic                  push_o,
  output opte_pkg::cmd_t        cmd_o
);

  assign in_ready_o = !fifo_status_i.full;
  assign push_o     = in_valid_i && !fifo_status_i.full;

  // Classify the operation; codes without meaning become a no-op command.
  always_comb begin
    cmd_o.direction    = in_req_i.direction;
    cmd_o.page_index   = in_req_i.page_index;
    cmd_o.column_index = in_req_i.column_index;
    cmd_o.new_byte     = in_req_i.new_byte;
    cmd_o.old_byte     = in_req_i.old_byte;
    case (in_req_i.operation)
      opte_pkg::OpStartShades: cmd_o.kind = opte_pkg::KindStartShades;
      opte_pkg::OpStartCrt:    cmd_o.kind = opte_pkg::KindStartCrt;
      opte_pkg::OpFrameBegin:  cmd_o.kind = opte_pkg::KindFrameBegin;
      opte_pkg::OpPixel:       cmd_o.kind = opte_pkg::KindPixel;
      opte_pkg::OpFrameEnd:    cmd_o.kind = opte_pkg::KindFrameEnd;
      default:                 cmd_o.kind = opte_pkg::KindNone;
    endcase
  end

endmodule

/* rtl/opte_fifo.sv */
module opte_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  opte_pkg::cmd_t         push_data_i,
  input  logic                   pop_i,
  output opte_pkg::cmd_t         pop_data_o,
  output opte_pkg::fifo_status_t status_o
);

  localparam logic [opte_pkg::FifoPtrW-1:0] LastPtr =
    opte_pkg::FifoPtrW'(opte_pkg::FifoDepth - 1);
  localparam logic [opte_pkg::FifoCntW-1:0] FullCnt =
    opte_pkg::FifoCntW'(opte_pkg::FifoDepth);

  opte_pkg::cmd_t                 mem_q [opte_pkg::FifoDepth];
  logic [opte_pkg::FifoPtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [opte_pkg::FifoPtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [opte_pkg::FifoCntW-1:0]  count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign pop_data_o     = mem_q[rd_ptr_q];
  assign status_o.empty = (count_q == '0);
  assign status_o.full  = (count_q == FullCnt);
  assign status_o.count = count_q;

endmodule

/* rtl/opte_back.sv */
module opte_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  opte_pkg::fifo_status_t fifo_status_i,
  input  opte_pkg::cmd_t         cmd_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output opte_pkg::out_req_t     out_req_o
);

  logic [1:0] effect_mode_q, effect_mode_d;
  logic [1:0] frame_effect_q, frame_effect_d;
  logic       shade_dir_q, shade_dir_d;
  logic [3:0] shade_step_q, shade_step_d;
  logic [5:0] crt_height_q, crt_height_d;
  logic [7:0] crt_width_q, crt_width_d;
  logic       crt_height_phase_q, crt_height_phase_d;
  logic       crt_opening_q, crt_opening_d;
  logic       out_valid_q;
  opte_pkg::out_req_t out_q, out_d;

  function automatic logic [7:0] render_shades(input logic dir, input logic [3:0] step,
                                               input logic [7:0] nb, input logic [7:0] ob);
    logic [2:0] sh;
    sh = (step >= 4'd8) ? 3'd0 : 3'(4'd8 - step);
    if (dir) begin
      return 8'(ob << 1) | 8'(nb >> sh);
    end
    return 8'(ob >> 1) | 8'(nb << sh);
  endfunction

  function automatic logic [7:0] render_crt(input logic [5:0] h, input logic [7:0] w,
                                            input logic [2:0] row, input logic [6:0] col,
                                            input logic [7:0] nb);
    logic [2:0] page;
    logic [2:0] prows;
    logic [6:0] half;
    logic [7:0] v;
    page  = h[5:3];
    prows = h[2:0];
    half  = w[7:1];
    v     = nb;
    // Rows outside the open band are blanked.
    if (row < page || ({1'b0, row} + {1'b0, page}) > 4'd7) begin
      v = 8'h00;
    end
    if (prows != 3'd0) begin
      // Partial page at each edge of the band: keep inside rows, draw the edge.
      if (row == page) begin
        v = (v & 8'(8'hFF << prows)) | 8'(8'h01 << (prows - 3'd1));
      end
      if (row == 3'd7 - page) begin
        v = (v & 8'(8'hFF >> prows)) | 8'(8'h80 >> (prows - 3'd1));
      end
    end else if (page != 3'd0 && ({1'b0, col} + {1'b0, half}) >= 8'd64 &&
                 {1'b0, col} < (8'd64 + {1'b0, half})) begin
      // Band on a page boundary: the centred line sits on the adjacent pages.
      if (row == page - 3'd1) begin
        v = 8'h80;
      end
      if ({1'b0, row} == 4'd8 - {1'b0, page}) begin
        v = 8'h01;
      end
    end
    return v;
  endfunction

  assign pop_o = !fifo_status_i.empty && (!out_valid_q || out_ready_i);

  always_comb begin
    logic [6:0] h_ext;
    logic [8:0] w_ext;
    logic       fin;
    logic [7:0] pix;
    effect_mode_d      = effect_mode_q;
    frame_effect_d     = frame_effect_q;
    shade_dir_d        = shade_dir_q;
    shade_step_d       = shade_step_q;
    crt_height_d       = crt_height_q;
    crt_width_d        = crt_width_q;
    crt_height_phase_d = crt_height_phase_q;
    crt_opening_d      = crt_opening_q;
    h_ext              = {1'b0, crt_height_q};
    w_ext              = {1'b0, crt_width_q};
    fin                = 1'b0;
    pix                = 8'h00;
    case (cmd_i.kind)
      opte_pkg::KindStartShades: begin
        shade_dir_d   = cmd_i.direction;
        shade_step_d  = 4'd1;
        effect_mode_d = opte_pkg::FxShades;
      end
      opte_pkg::KindStartCrt: begin
        if (cmd_i.direction) begin
          crt_height_d       = 6'd32;
          crt_width_d        = 8'd0;
          crt_height_phase_d = 1'b0;
          crt_opening_d      = 1'b1;
        end else begin
          crt_height_d       = 6'd1;
          crt_width_d        = 8'd128;
          crt_height_phase_d = 1'b1;
          crt_opening_d      = 1'b0;
        end
        effect_mode_d = opte_pkg::FxCrt;
      end
      opte_pkg::KindFrameBegin: begin
        frame_effect_d = effect_mode_q;
        if (effect_mode_q == opte_pkg::FxCrt) begin
          if (crt_height_phase_q) begin
            if (crt_opening_q) begin
              if (crt_height_q <= 6'd9) begin
                crt_height_d  = 6'd1;
                effect_mode_d = opte_pkg::FxIdle;
              end else begin
                crt_height_d = crt_height_q - 6'd8;
              end
            end else begin
              h_ext = h_ext + 7'd4;
              if (h_ext >= 7'd32) begin
                crt_height_d       = 6'd32;
                crt_height_phase_d = 1'b0;
              end else begin
                crt_height_d = h_ext[5:0];
              end
            end
          end else begin
            if (crt_opening_q) begin
              w_ext = w_ext + 9'd30;
              if (w_ext >= 9'd128) begin
                crt_width_d        = 8'd128;
                crt_height_phase_d = 1'b1;
              end else begin
                crt_width_d = w_ext[7:0];
              end
            end else begin
              if (crt_width_q <= 8'd20) begin
                crt_width_d   = 8'd0;
                effect_mode_d = opte_pkg::FxIdle;
                fin           = 1'b1;
              end else begin
                crt_width_d = crt_width_q - 8'd20;
              end
            end
          end
        end
      end
      opte_pkg::KindPixel: begin
        if (frame_effect_q == opte_pkg::FxShades) begin
          pix = render_shades(shade_dir_q, shade_step_q, cmd_i.new_byte, cmd_i.old_byte);
        end else if (frame_effect_q == opte_pkg::FxCrt) begin
          pix = render_crt(crt_height_q, crt_width_q, cmd_i.page_index,
                           cmd_i.column_index, cmd_i.new_byte);
        end else begin
          pix = cmd_i.new_byte;
        end
      end
      opte_pkg::KindFrameEnd: begin
        if (effect_mode_q == opte_pkg::FxShades && frame_effect_q == opte_pkg::FxShades) begin
          if (shade_step_q < 4'd15) begin
            shade_step_d = shade_step_q + 4'd1;
          end
          if (shade_step_d >= 4'd8) begin
            effect_mode_d = opte_pkg::FxIdle;
          end
        end
        frame_effect_d = opte_pkg::FxIdle;
      end
      default: begin
      end
    endcase
    out_d.pixel_out     = pix;
    out_d.active_effect = effect_mode_d;
    out_d.finish_flag   = fin;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      effect_mode_q      <= opte_pkg::FxIdle;
      frame_effect_q     <= opte_pkg::FxIdle;
      shade_dir_q        <= 1'b1;
      shade_step_q       <= 4'd1;
      crt_height_q       <= 6'd0;
      crt_width_q        <= 8'd0;
      crt_height_phase_q <= 1'b0;
      crt_opening_q      <= 1'b0;
      out_valid_q        <= 1'b0;
    end else begin
      if (pop_o) begin
        effect_mode_q      <= effect_mode_d;
        frame_effect_q     <= frame_effect_d;
        shade_dir_q        <= shade_dir_d;
        shade_step_q       <= shade_step_d;
        crt_height_q       <= crt_height_d;
        crt_width_q        <= crt_width_d;
        crt_height_phase_q <= crt_height_phase_d;
        crt_opening_q      <= crt_opening_d;
        out_valid_q        <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

endmodule

/* rtl/oled_page_transition_engine_unit.sv */
// An accepted request is written into the command queue, then into the output register.
// Throughput: one request per cycle unless the output stalls; one command retires a cycle.
// A four-entry command queue absorbs output stalls, so input ready drops only when it is full.
// Reset (rst_ni low, asynchronous) empties the queue, drops output valid and puts the
// effect state in idle with shade direction down and shade step one.
module oled_page_transition_engine_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  opte_pkg::in_req_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output opte_pkg::out_req_t out_req_o
);

  // The front end decodes each request into a command and pushes it into the queue.
  // It never reads effect state, so it accepts during back end stalls until the queue is full.
  logic                   push;
  logic                   pop;
  opte_pkg::cmd_t         push_cmd;
  opte_pkg::cmd_t         head_cmd;
  opte_pkg::fifo_status_t fifo_status;

  opte_front u_front (
    .in_valid_i    (in_valid_i),
    .in_req_i      (in_req_i),
    .in_ready_o    (in_ready_o),
    .fifo_status_i (fifo_status),
    .push_o        (push),
    .cmd_o         (push_cmd)
  );

  // The queue decouples the two halves; its head is read combinationally by the back end.
  opte_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .pop_i       (pop),
    .pop_data_o  (head_cmd),
    .status_o    (fifo_status)
  );

  // The back end owns all effect state. It executes the head command, renders the byte,
  // and loads the output register whenever that register is empty or being drained.
  opte_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fifo_status_i (fifo_status),
    .cmd_i         (head_cmd),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_req_o     (out_req_o)
  );

  // A finishing closing effect always leaves the block idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_req_o.finish_flag) |-> (out_req_o.active_effect == opte_pkg::FxIdle))
    else $error("finish flag raised while an effect stays active");

  // The queue occupancy never exceeds its depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_status.count <= opte_pkg::FifoCntW'(opte_pkg::FifoDepth))
    else $error("command queue overflow");

  // A request entering an empty queue reaches the output register once the output is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && fifo_status.empty) ##1 (!out_valid_o || out_ready_i)
      |=> out_valid_o)
    else $error("request did not reach the output register");

  // Nothing is popped from an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !fifo_status.empty)
    else $error("pop from empty command queue");

endmodule

/* tb/opte_transition_checker.sv */
module opte_transition_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  opte_pkg::in_req_t  in_req_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  opte_pkg::out_req_t out_req_i,
  output int                 fail_count_o,
  output int                 request_count_o,
  output int                 result_count_o,
  output int                 finish_count_o
);
  import opte_pkg::*;

  // Shadow copy of the effect state.
  logic [1:0] mode_q;
  logic [1:0] frame_fx_q;
  logic       shade_dir_q;
  logic [3:0] shade_step_q;
  logic [5:0] crt_height_q;
  logic [7:0] crt_width_q;
  logic       height_phase_q;
  logic       opening_q;

  out_req_t predicted_renders[$];
  out_req_t want;
  int       fails;
  int       requests;
  int       results;
  int       finishes;

  // Applies one request to the shadow state and returns the result it renders.
  function automatic out_req_t render_transition(input in_req_t req);
    out_req_t   res;
    int         h;
    int         w;
    int         shift;
    int         page;
    int         prows;
    int         row;
    int         col;
    int         half;
    logic [15:0] wide;
    logic [7:0] v;
    res = '0;
    case (req.operation)
      OpStartShades: begin
        shade_dir_q  = req.direction;
        shade_step_q = 4'd1;
        mode_q       = FxShades;
      end
      OpStartCrt: begin
        if (req.direction) begin
          crt_height_q   = 6'd32;
          crt_width_q    = 8'd0;
          height_phase_q = 1'b0;
          opening_q      = 1'b1;
        end else begin
          crt_height_q   = 6'd1;
          crt_width_q    = 8'd128;
          height_phase_q = 1'b1;
          opening_q      = 1'b0;
        end
        mode_q = FxCrt;
      end
      OpFrameBegin: begin
        frame_fx_q = mode_q;
        if (mode_q == FxCrt) begin
          h = crt_height_q;
          w = crt_width_q;
          if (height_phase_q) begin
            if (opening_q) begin
              if (h <= 9) begin
                h      = 1;
                mode_q = FxIdle;
              end else begin
                h = h - 8;
              end
            end else begin
              h = h + 4;
              if (h >= 32) begin
                h              = 32;
                height_phase_q = 1'b0;
              end
            end
          end else if (opening_q) begin
            w = w + 30;
            if (w >= 128) begin
              w              = 128;
              height_phase_q = 1'b1;
            end
          end else if (w <= 20) begin
            w               = 0;
            mode_q          = FxIdle;
            res.finish_flag = 1'b1;
          end else begin
            w = w - 20;
          end
          crt_height_q = h[5:0];
          crt_width_q  = w[7:0];
        end
      end
      OpPixel: begin
        if (frame_fx_q == FxShades) begin
          shift = (shade_step_q >= 4'd8) ? 0 : 8 - int'(shade_step_q);
          if (req.new_byte == 8'h00 && req.old_byte == 8'h00) begin
            wide = '0;
          end else if (shade_dir_q) begin
            wide = ({8'h00, req.old_byte} << 1) | ({8'h00, req.new_byte} >> shift);
          end else begin
            wide = ({8'h00, req.old_byte} >> 1) | ({8'h00, req.new_byte} << shift);
          end
          res.pixel_out = wide[7:0];
        end else if (frame_fx_q == FxCrt) begin
          page  = crt_height_q / 8;
          prows = crt_height_q % 8;
          row   = req.page_index;
          col   = req.column_index;
          half  = crt_width_q / 2;
          v     = req.new_byte;
          if (row < page || (7 - row) < page) v = 8'h00;
          // Later rules overwrite earlier ones, so the order matters.
          if (prows != 0) begin
            if (row == page) v = (v & (8'hFF << prows)) | (8'h01 << (prows - 1));
            if (row == 7 - page) v = (v & (8'hFF >> prows)) | (8'h80 >> (prows - 1));
          end else if (page >= 1 && col >= 64 - half && col < 64 + half) begin
            if (row == page - 1) v = 8'h80;
            if (row == 8 - page) v = 8'h01;
          end
          res.pixel_out = v;
        end else begin
          res.pixel_out = req.new_byte;
        end
      end
      OpFrameEnd: begin
        if (mode_q == FxShades && frame_fx_q == FxShades) begin
          if (shade_step_q < 4'd15) shade_step_q = shade_step_q + 4'd1;
          if (shade_step_q >= 4'd8) mode_q = FxIdle;
        end
        frame_fx_q = FxIdle;
      end
      default: begin
      end
    endcase
    res.active_effect = mode_q;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q         = FxIdle;
      frame_fx_q     = FxIdle;
      shade_dir_q    = 1'b1;
      shade_step_q   = 4'd1;
      crt_height_q   = 6'd0;
      crt_width_q    = 8'd0;
      height_phase_q = 1'b0;
      opening_q      = 1'b0;
      predicted_renders.delete();
      fails    = 0;
      requests = 0;
      results  = 0;
      finishes = 0;
    end else begin
      // A result can only belong to a request taken at an earlier edge.
      if (out_valid_i && out_ready_i) begin
        results++;
        if (predicted_renders.size() == 0) begin
          $error("unexpected result: pixel_out %0h active_effect %0d finish_flag %0b",
                 out_req_i.pixel_out, out_req_i.active_effect, out_req_i.finish_flag);
          fails++;
        end else begin
          want = predicted_renders.pop_front();
          if (out_req_i.pixel_out !== want.pixel_out) begin
            $error("pixel_out: expected %0h, actual %0h", want.pixel_out, out_req_i.pixel_out);
            fails++;
          end
          if (out_req_i.active_effect !== want.active_effect) begin
            $error("active_effect: expected %0d, actual %0d",
                   want.active_effect, out_req_i.active_effect);
            fails++;
          end
          if (out_req_i.finish_flag !== want.finish_flag) begin
            $error("finish_flag: expected %0b, actual %0b",
                   want.finish_flag, out_req_i.finish_flag);
            fails++;
          end
          if (want.finish_flag) finishes++;
        end
      end
      if (in_valid_i && in_ready_i) begin
        predicted_renders.push_back(render_transition(in_req_i));
        requests++;
      end
    end
    fail_count_o    <= fails;
    request_count_o <= requests;
    result_count_o  <= results;
    finish_count_o  <= finishes;
  end

endmodule

/* tb/oled_page_transition_engine_unit_tb.sv */
module oled_page_transition_engine_unit_tb;
  import opte_pkg::*;

  // Operation codes the block must treat as no-ops.
  localparam logic [2:0] OpUnusedLo  = 3'd5;
  localparam logic [2:0] OpUnusedMid = 3'd6;
  localparam logic [2:0] OpUnusedHi  = 3'd7;

  // Number of requests in the random part of the run.
  localparam int RandomItems = 1050;
  // Near the end of the run both sides stop idling for this many requests.
  localparam int CalmTail = 150;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  in_req_t  in_req    = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  out_req_t out_req;

  int fail_count;
  int request_count;
  int result_count;
  int finish_count;

  int sent = 0;
  int random_base;
  // When calm is set neither side idles; steady suppresses sender gaps for one
  // whole sequence so that long unbroken stretches also occur.
  bit calm   = 1'b0;
  bit steady = 1'b0;

  // The clock runs with a 12 unit period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  oled_page_transition_engine_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_req_o   (out_req)
  );

  // The checker watches both channels, predicts every result and compares.
  opte_transition_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .in_req_i        (in_req),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .out_req_i       (out_req),
    .fail_count_o    (fail_count),
    .request_count_o (request_count),
    .result_count_o  (result_count),
    .finish_count_o  (finish_count)
  );

  // Builds a request with every field given explicitly.
  function automatic in_req_t make_req(input logic [2:0] op, input logic dir,
                                       input logic [2:0] pg, input logic [6:0] col,
                                       input logic [7:0] nb, input logic [7:0] ob);
    in_req_t r;
    r.operation    = op;
    r.direction    = dir;
    r.page_index   = pg;
    r.column_index = col;
    r.new_byte     = nb;
    r.old_byte     = ob;
    return r;
  endfunction

  // Builds a request of the given operation with the remaining fields random.
  // Fields that the operation ignores still toggle so every input bit moves.
  function automatic in_req_t random_req(input logic [2:0] op);
    return make_req(op, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                    7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)));
  endfunction

  // Pixel bytes lean toward all-zero and all-one values, which are the
  // interesting corners of both the shades mix and the crt masks.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // A random pixel request. Columns favor the frame edges and the band around
  // the center where the crt line is drawn.
  function automatic in_req_t pixel_req();
    in_req_t r;
    r = random_req(OpPixel);
    case ($urandom_range(0, 4))
      0: r.column_index = 7'd0;
      1: r.column_index = 7'd127;
      2: r.column_index = 7'($urandom_range(30, 97));
      default: r.column_index = 7'($urandom_range(0, 127));
    endcase
    r.new_byte = pick_byte();
    r.old_byte = pick_byte();
    return r;
  endfunction

  // Offers one request and returns once the block has taken it. Valid is left
  // high so that back-to-back requests keep it asserted without a glitch.
  task automatic send_request(input in_req_t req);
    int gap;
    if (!calm && !steady && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 18);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  // Holds off new requests until every predicted result has come back. The
  // counters are registered, so the first edge is always waited out.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (request_count != result_count);
  endtask

  // One random transition: usually a start request, then a run of frames. Most
  // frames are well formed; a few lose their begin or end marker, and noise
  // requests of any code (starts included) are sprinkled between the pixels.
  task automatic run_sequence();
    int   frames;
    int   pixels;
    int   effect;
    logic dir;
    effect = $urandom_range(0, 3);
    dir    = 1'($urandom_range(0, 1));
    steady = ($urandom_range(0, 3) == 0);
    if (effect == 0) begin
      send_request(make_req(OpStartShades, dir, 3'($urandom_range(0, 7)),
                            7'($urandom_range(0, 127)), pick_byte(), pick_byte()));
      frames = $urandom_range(3, 10);
    end else if (effect <= 2) begin
      // A closing crt needs about fifteen frames to reach its finish.
      send_request(make_req(OpStartCrt, dir, 3'($urandom_range(0, 7)),
                            7'($urandom_range(0, 127)), pick_byte(), pick_byte()));
      frames = $urandom_range(4, 18);
    end else begin
      frames = $urandom_range(1, 3);
    end
    repeat (frames) begin
      if ($urandom_range(0, 15) != 0) send_request(random_req(OpFrameBegin));
      pixels = $urandom_range(1, 6);
      repeat (pixels) begin
        if ($urandom_range(0, 11) == 0) send_request(random_req(3'($urandom_range(0, 7))));
        send_request(pixel_req());
      end
      if ($urandom_range(0, 15) != 0) send_request(random_req(OpFrameEnd));
      // Bytes between a frame end and the next begin must pass through.
      if ($urandom_range(0, 9) == 0) send_request(pixel_req());
    end
    steady = 1'b0;
  endtask

  // Output side: random stall bursts, occasional long stretches of no stalls,
  // and no stalls at all once the run has gone calm.
  initial begin
    @(posedge clk);
    out_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (!calm) begin
        if ($urandom_range(0, 39) == 0) begin
          repeat ($urandom_range(30, 100)) @(posedge clk);
        end else if ($urandom_range(0, 5) == 0) begin
          out_ready <= 1'b0;
          repeat ($urandom_range(1, 18)) @(posedge clk);
          out_ready <= 1'b1;
        end
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Idle pass-through right after reset, at the corners of the frame.
    send_request(make_req(OpPixel, 1'b0, 3'd0, 7'd0, 8'hFF, 8'h00));
    send_request(make_req(OpPixel, 1'b1, 3'd7, 7'd127, 8'h00, 8'hFF));
    // Unused codes change nothing and render zero.
    send_request(make_req(OpUnusedLo, 1'b1, 3'd7, 7'd127, 8'hFF, 8'hFF));
    send_request(make_req(OpUnusedMid, 1'b0, 3'd0, 7'd0, 8'h00, 8'h00));
    send_request(make_req(OpUnusedHi, 1'b1, 3'd5, 7'd85, 8'hAA, 8'h55));
    send_request(make_req(OpFrameEnd, 1'b0, 3'd0, 7'd0, 8'h00, 8'h00));
    // Shades moving up, including a byte where both frames are blank.
    send_request(make_req(OpStartShades, 1'b0, 3'd0, 7'd0, 8'h00, 8'h00));
    send_request(make_req(OpFrameBegin, 1'b0, 3'd0, 7'd0, 8'h00, 8'h00));
    send_request(make_req(OpPixel, 1'b0, 3'd2, 7'd10, 8'h00, 8'h00));
    send_request(make_req(OpPixel, 1'b0, 3'd3, 7'd64, 8'hFF, 8'hFF));
    // A crt start in the middle of a frame only takes hold at the next begin.
    send_request(make_req(OpStartCrt, 1'b1, 3'd0, 7'd0, 8'h00, 8'h00));
    send_request(make_req(OpPixel, 1'b0, 3'd4, 7'd63, 8'h80, 8'h01));
    send_request(make_req(OpFrameEnd, 1'b0, 3'd0, 7'd0, 8'h00, 8'h00));
    send_request(make_req(OpPixel, 1'b0, 3'd1, 7'd1, 8'h5A, 8'hA5));
    // Opening crt frame: the line grows from the center.
    send_request(make_req(OpFrameBegin, 1'b0, 3'd0, 7'd0, 8'h00, 8'h00));
    send_request(make_req(OpPixel, 1'b0, 3'd3, 7'd64, 8'hFF, 8'h00));
    send_request(make_req(OpPixel, 1'b0, 3'd0, 7'd0, 8'hFF, 8'h00));
    send_request(make_req(OpFrameEnd, 1'b0, 3'd0, 7'd0, 8'h00, 8'h00));
    // Closing crt frame: the picture is masked down to a thin band.
    send_request(make_req(OpStartCrt, 1'b0, 3'd0, 7'd0, 8'h00, 8'h00));
    send_request(make_req(OpFrameBegin, 1'b0, 3'd0, 7'd0, 8'h00, 8'h00));
    send_request(make_req(OpPixel, 1'b0, 3'd0, 7'd63, 8'hFF, 8'hFF));
    send_request(make_req(OpPixel, 1'b0, 3'd7, 7'd64, 8'hFF, 8'hFF));
    send_request(make_req(OpFrameEnd, 1'b0, 3'd0, 7'd0, 8'h00, 8'h00));
    // Shades moving down, left running into the random part.
    send_request(make_req(OpStartShades, 1'b1, 3'd0, 7'd0, 8'h00, 8'h00));

    // Let the block drain completely once before the random part.
    wait_for_results();

    random_base = sent;
    while (sent < random_base + RandomItems) begin
      if (sent >= random_base + RandomItems - CalmTail) calm <= 1'b1;
      run_sequence();
      if ($urandom_range(0, 5) == 0) wait_for_results();
    end

    wait_for_results();
    repeat (10) @(posedge clk);

    $display("Covered shades up and down, crt opening and closing, mid-frame starts,");
    $display("pass-through and unused codes: %0d requests, %0d results, %0d crt finishes.",
             request_count, result_count, finish_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #12000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
